@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sorted priority queue block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SPQF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds whenever the antecedent does.
`define SPQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SPQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SPQF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/spqf_pkg.sv @@
// Types and constants of the sorted priority queue find block.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package spqf_pkg;

	localparam int VAL_W = 32;
	localparam int CNT_W = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FIND   = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] position;
		logic [CNT_W-1:0] entry_count;
		logic             dropped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_FND_RD,
		ST_FND_CMP
	} state_t;

endpackage

`default_nettype wire

@@ rtl/spqf_store.sv @@
// Value store of the sorted priority queue: one write port, one registered read port.
// Depends on spqf_pkg for the value width.
`default_nettype none

module spqf_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [AW-1:0]                    wr_addr,
	input  wire logic signed [spqf_pkg::VAL_W-1:0] wr_data,
	input  wire logic [AW-1:0]                    rd_addr,
	output logic signed [spqf_pkg::VAL_W-1:0]      rd_data
);
	import spqf_pkg::*;

	logic signed [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue_find_unit.sv @@
// Top level of the sorted priority queue find block: sequencer, shared comparator, count.
// Depends on spqf_pkg, spqf_store and assert_macros.svh.
`default_nettype none

// Usage
//   A request (action, value) is taken at a rising edge where start is high and
//   busy is low. action ACT_INSERT puts value into the store, kept in descending
//   order, ahead of any equal values; ACT_FIND looks for value and reports the
//   1-based position of its first occurrence. Each request yields exactly one
//   result: done is high for one cycle and result carries found, position,
//   entry_count (count after the request) and dropped (insert into a full store).
// Timing
//   One comparator walks the store one entry at a time: it addresses the memory
//   read port, then compares the registered read data.
//   An insert walks from the tail toward the head and ends at the first greater
//   entry or at the head. A find walks from the head and ends at a match, at the
//   first smaller entry or past the last entry. An insert into a full store
//   never raises busy.
//   done rises in the cycle after the request completes; a new request may be
//   taken in that same cycle.
// Reset
//   arst_n clears the count and the sequencer; store contents are not cleared
//   and entries past the count are never compared. The receiver cannot stall, so
//   the result must be captured while done is high.
module sorted_priority_queue_find_unit #(
	parameter int CAPACITY = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire spqf_pkg::req_t  request,
	output logic                 done,
	output spqf_pkg::rsp_t       result
);
	import spqf_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                  state_q, state_d;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           idx_dec;
	logic [CW:0]             idx_inc;
	logic signed [VAL_W-1:0] key_q;
	logic signed [VAL_W-1:0] rd_data;
	rsp_t                    rsp_q;
	logic                    done_q;

	// store controls
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic [AW-1:0]           rd_addr;

	// completion flags
	logic take;
	logic full;
	logic fin;
	logic fin_ins;
	logic fin_drop;
	logic hit;

	// shared comparator
	logic gt;
	logic eq;
	logic lt;

	assign take    = start && (state_q == ST_IDLE);
	assign full    = (count_q == CW'(CAPACITY));
	assign idx_dec = idx_q - CW'(1);
	assign idx_inc = {1'b0, idx_q} + (CW + 1)'(1);

	assign gt = rd_data > key_q;
	assign eq = rd_data == key_q;
	assign lt = !gt && !eq;

	spqf_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (request.action == ACT_FIND) begin
						state_d = ST_FND_RD;
					end else if (!full) begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_INS_RD: begin
				state_d = (idx_q == '0) ? ST_IDLE : ST_INS_CMP;
			end
			ST_INS_CMP: begin
				state_d = gt ? ST_IDLE : ST_INS_RD;
			end
			ST_FND_RD: begin
				state_d = (idx_q == count_q) ? ST_IDLE : ST_FND_CMP;
			end
			ST_FND_CMP: begin
				state_d = (eq || lt) ? ST_IDLE : ST_FND_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Store controls and completion flags
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q[AW-1:0];
		wr_data  = key_q;
		rd_addr  = idx_q[AW-1:0];
		fin      = 1'b0;
		fin_ins  = 1'b0;
		fin_drop = 1'b0;
		hit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// an insert into a full store completes at once
				if (take && request.action == ACT_INSERT && full) begin
					fin      = 1'b1;
					fin_drop = 1'b1;
				end
			end
			ST_INS_RD: begin
				rd_addr = idx_dec[AW-1:0];
				// reached the head: place the key there
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					fin     = 1'b1;
					fin_ins = 1'b1;
				end
			end
			ST_INS_CMP: begin
				// greater neighbor: key lands here, otherwise shift the neighbor down
				wr_en   = 1'b1;
				wr_data = gt ? key_q : rd_data;
				fin     = gt;
				fin_ins = gt;
			end
			ST_FND_RD: begin
				fin = (idx_q == count_q);
			end
			ST_FND_CMP: begin
				fin = eq || lt;
				hit = eq;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (fin_ins) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Key, scan index and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= request.value;
			idx_q <= (request.action == ACT_INSERT) ? count_q : '0;
		end else if (state_q == ST_INS_CMP && !gt) begin
			idx_q <= idx_dec;
		end else if (state_q == ST_FND_CMP && !eq && !lt) begin
			idx_q <= idx_inc[CW-1:0];
		end
		if (fin) begin
			rsp_q.found       <= hit;
			rsp_q.position    <= hit ? CNT_W'(idx_inc) : '0;
			rsp_q.entry_count <= fin_ins ? CNT_W'(count_q + CW'(1)) : CNT_W'(count_q);
			rsp_q.dropped     <= fin_drop;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

`include "assert_macros.svh"

	`SPQF_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY), "count above capacity")
	`SPQF_ASSERT_NXT(a_take_reacts, clk, arst_n, take, busy || done, "request not acted on")
	`SPQF_ASSERT_IMP(a_found_pos, clk, arst_n, done && result.found, result.position != '0 && !result.dropped, "found result without position")
	`SPQF_ASSERT_IMP(a_count_step, clk, arst_n, count_q != $past(count_q), count_q == $past(count_q) + CW'(1), "count moved by more than one")
	`SPQF_ASSERT_IMP(a_drop_full, clk, arst_n, done && result.dropped, !$past(busy) && $past(full), "drop without full store")

endmodule

`default_nettype wire
